// ===== src/lac_pkg.sv =====
// Shared types and constants for the luminance autocontrast unit.
package lac_pkg;

   localparam int CHAN_W  = 8;
   localparam int LUMA_W  = 24;
   localparam int TRIM_W  = 15;
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 16;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int NUMER_W = 32;

   localparam logic [MUL_B_W-1:0] WEIGHT_RED   = 16'd13926;
   localparam logic [MUL_B_W-1:0] WEIGHT_GREEN = 16'd46885;
   localparam logic [MUL_B_W-1:0] WEIGHT_BLUE  = 16'd4725;

   localparam logic [LUMA_W-1:0] LUMA_START_MIN = 24'hFF0000;
   localparam logic [LUMA_W-1:0] LUMA_START_MAX = 24'h000000;
   localparam logic [TRIM_W-1:0] TRIM_RESET     = 15'd655;
   localparam logic [CHAN_W-1:0] CHAN_FULL      = 8'd255;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_APPLY   = 1'b1;

   typedef struct packed {
      logic [MUL_A_W-1:0] multiplicand;
      logic [MUL_B_W-1:0] multiplier;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [NUMER_W-1:0] numer;
      logic [LUMA_W-1:0]  denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CHAN_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== src/lac_mul.sv =====
// Shared registered multiplier used for luminance weights and range trimming.
module lac_mul (
   input  logic                         clock,
   input  lac_pkg::mul_req_type         mul_req,
   output logic [lac_pkg::PROD_W-1:0]   product
);
   import lac_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = {{MUL_B_W{1'b0}}, mul_req.multiplicand}
                     * {{MUL_A_W{1'b0}}, mul_req.multiplier};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== src/lac_div.sv =====
// Restoring divider giving an 8-bit quotient that saturates at 255.
module lac_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lac_pkg::div_req_type div_req,
   output lac_pkg::div_rsp_type div_rsp
);
   import lac_pkg::*;

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [NUMER_W-1:0]   rem_ff, rem_in;
   logic [NUMER_W-2:0]   dsh_ff, dsh_in;
   logic [CHAN_W-1:0]    quot_ff, quot_in;
   logic                 step_ge;
   logic                 overflow;

   // Any quotient of 256 or more clamps, so only eight quotient bits are formed.
   assign overflow = div_req.numer >= {div_req.denom, 8'b0};
   assign step_ge  = rem_ff >= {1'b0, dsh_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quot_in   = quot_ff;
      if (div_req.start) begin
         if (overflow) begin
            quot_in   = CHAN_FULL;
            done_in   = 1'b1;
            active_in = 1'b0;
         end else begin
            rem_in    = div_req.numer;
            dsh_in    = {div_req.denom, 7'b0};
            cnt_in    = 3'd7;
            quot_in   = '0;
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         if (step_ge) begin
            rem_in = rem_ff - {1'b0, dsh_ff};
         end
         quot_in = {quot_ff[CHAN_W-2:0], step_ge};
         dsh_in  = {1'b0, dsh_ff[NUMER_W-2:1]};
         cnt_in  = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== src/luminance_autocontrast_unit.sv =====
// Top level of the luminance autocontrast unit: sequencer, range state and result word.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  opcode, first_pixel, red/green/blue_in
//   rsp_      out        rsp_valid/rsp_stall  red/green/blue_out, range_error
//   csr_      in         csr_write_enable     csr_write_data (trim_fraction)
//
// A measure word makes three passes through the shared multiplier and then a fold.
// An apply word runs two trim multiplies and a range check, then, if the range is valid,
// per channel a setup step and a divide unless it clamps to zero, then loads the result.
// Reset is synchronous; the range restarts at minimum 255.0 and maximum 0.
// The unit takes a new word while a finished result waits under rsp_stall, and holds
// a later result in its final state until the output register is free.
module luminance_autocontrast_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic       req_first_pixel,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic       rsp_range_error,
   input  logic       csr_write_enable,
   input  logic [14:0] csr_write_data
);
   import lac_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LUMA = 4'd1;
   localparam logic [3:0] S_FOLD = 4'd2;
   localparam logic [3:0] S_T1   = 4'd3;
   localparam logic [3:0] S_T1W  = 4'd4;
   localparam logic [3:0] S_T2   = 4'd5;
   localparam logic [3:0] S_T2W  = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_CH   = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   localparam int SW = LUMA_W + 2;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          lcnt_ff, lcnt_in;
   logic [1:0]          chan_ff, chan_in;
   logic                first_ff, first_in;
   logic [CHAN_W-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [LUMA_W-1:0]   acc_ff, acc_in;
   logic [LUMA_W-1:0]   min_ff, min_in, max_ff, max_in;
   logic [TRIM_W-1:0]   trim_ff, trim_in;
   logic                neg_ff, neg_in;
   logic signed [SW-1:0] high_ff, high_in, low_ff, low_in;
   logic [LUMA_W-1:0]   denom_ff, denom_in;
   logic [CHAN_W-1:0]   chan_q_ff [3];
   logic [CHAN_W-1:0]   chan_q_in [3];
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]   rsp_blue_ff, rsp_blue_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                req_accept;
   logic                out_free;
   logic [PROD_W-1:0]   product;
   mul_req_type         mul_req;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [LUMA_W-1:0]   luma;
   logic [LUMA_W-1:0]   min_eff, max_eff;
   logic signed [SW-1:0] span_s, diff_s, trim_t, stretch_x;
   logic [LUMA_W-1:0]   span_mag, diff_mag;
   logic [CHAN_W-1:0]   chan_pix;
   logic [LUMA_W-1:0]   x_mag;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign luma    = acc_ff;
   assign min_eff = first_ff ? LUMA_START_MIN : min_ff;
   assign max_eff = first_ff ? LUMA_START_MAX : max_ff;

   // Trim terms are worked in sign and magnitude so the product truncates toward zero.
   assign span_s   = $signed({2'b00, max_ff}) - $signed({2'b00, min_ff});
   assign diff_s   = high_ff - $signed({2'b00, min_ff});
   assign span_mag = span_s[SW-1] ? LUMA_W'(-span_s) : span_s[LUMA_W-1:0];
   assign diff_mag = diff_s[SW-1] ? LUMA_W'(-diff_s) : diff_s[LUMA_W-1:0];
   assign trim_t   = $signed({2'b00, product[PROD_W-1:MUL_B_W]});

   always_comb begin
      case (chan_ff)
         2'd0:    chan_pix = red_ff;
         2'd1:    chan_pix = green_ff;
         default: chan_pix = blue_ff;
      endcase
   end

   assign stretch_x = $signed({2'b00, chan_pix, 16'b0}) - low_ff;
   assign x_mag     = stretch_x[LUMA_W-1:0];

   always_comb begin
      mul_req.multiplicand = '0;
      mul_req.multiplier   = '0;
      case (state_ff)
         S_LUMA: begin
            case (lcnt_ff)
               2'd0: begin
                  mul_req.multiplicand = {16'b0, red_ff};
                  mul_req.multiplier   = WEIGHT_RED;
               end
               2'd1: begin
                  mul_req.multiplicand = {16'b0, green_ff};
                  mul_req.multiplier   = WEIGHT_GREEN;
               end
               2'd2: begin
                  mul_req.multiplicand = {16'b0, blue_ff};
                  mul_req.multiplier   = WEIGHT_BLUE;
               end
               default: begin
                  mul_req.multiplicand = '0;
                  mul_req.multiplier   = '0;
               end
            endcase
         end
         S_T1: begin
            mul_req.multiplicand = span_mag;
            mul_req.multiplier   = {1'b0, trim_ff};
         end
         S_T2: begin
            mul_req.multiplicand = diff_mag;
            mul_req.multiplier   = {1'b0, trim_ff};
         end
         default: begin
            mul_req.multiplicand = '0;
            mul_req.multiplier   = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      lcnt_in      = lcnt_ff;
      chan_in      = chan_ff;
      first_in     = first_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      acc_in       = acc_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      trim_in      = csr_write_enable ? csr_write_data : trim_ff;
      neg_in       = neg_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      denom_in     = denom_ff;
      chan_q_in    = chan_q_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_err_in   = rsp_err_ff;
      div_req.start = 1'b0;
      div_req.numer = {x_mag, 8'b0} - {8'b0, x_mag};
      div_req.denom = denom_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               first_in = req_first_pixel;
               red_in   = req_red_in;
               green_in = req_green_in;
               blue_in  = req_blue_in;
               lcnt_in  = 2'd0;
               acc_in   = '0;
               state_in = (req_opcode == OP_APPLY) ? S_T1 : S_LUMA;
            end
         end
         S_LUMA: begin
            // The product of the previous weight arrives in the cycle after issue.
            if (lcnt_ff != 2'd0) begin
               acc_in = acc_ff + product[LUMA_W-1:0];
            end
            lcnt_in = lcnt_ff + 2'd1;
            if (lcnt_ff == 2'd3) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            min_in   = (luma < min_eff) ? luma : min_eff;
            max_in   = (luma > max_eff) ? luma : max_eff;
            state_in = S_IDLE;
         end
         S_T1: begin
            neg_in   = span_s[SW-1];
            state_in = S_T1W;
         end
         S_T1W: begin
            high_in  = neg_ff ? $signed({2'b00, max_ff}) + trim_t
                              : $signed({2'b00, max_ff}) - trim_t;
            state_in = S_T2;
         end
         S_T2: begin
            neg_in   = diff_s[SW-1];
            state_in = S_T2W;
         end
         S_T2W: begin
            low_in   = neg_ff ? $signed({2'b00, min_ff}) - trim_t
                              : $signed({2'b00, min_ff}) + trim_t;
            state_in = S_CHK;
         end
         S_CHK: begin
            chan_in = 2'd0;
            if (high_ff <= low_ff) begin
               err_in       = 1'b1;
               chan_q_in[0] = '0;
               chan_q_in[1] = '0;
               chan_q_in[2] = '0;
               state_in     = S_OUT;
            end else begin
               err_in   = 1'b0;
               denom_in = LUMA_W'(high_ff - low_ff);
               state_in = S_CH;
            end
         end
         S_CH: begin
            if (stretch_x[SW-1] || (stretch_x == '0)) begin
               // At or below the trimmed low the channel clamps to zero.
               chan_q_in[chan_ff] = '0;
               chan_in            = chan_ff + 2'd1;
               state_in           = (chan_ff == 2'd2) ? S_OUT : S_CH;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               chan_q_in[chan_ff] = div_rsp.quot;
               chan_in            = chan_ff + 2'd1;
               state_in           = (chan_ff == 2'd2) ? S_OUT : S_CH;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = chan_q_ff[0];
               rsp_green_in = chan_q_ff[1];
               rsp_blue_in  = chan_q_ff[2];
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= LUMA_START_MIN;
         max_ff       <= LUMA_START_MAX;
         trim_ff      <= TRIM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         trim_ff      <= trim_in;
      end
      lcnt_ff      <= lcnt_in;
      chan_ff      <= chan_in;
      first_ff     <= first_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      high_ff      <= high_in;
      low_ff       <= low_in;
      denom_ff     <= denom_in;
      chan_q_ff    <= chan_q_in;
      err_ff       <= err_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_err_ff   <= rsp_err_in;
   end

   lac_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   lac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = rsp_red_ff;
   assign rsp_green_out   = rsp_green_ff;
   assign rsp_blue_out    = rsp_blue_ff;
   assign rsp_range_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         (rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0))
      else $error("range error word carries nonzero channels");

   a_fold_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD) |=> (min_ff <= max_ff))
      else $error("luminance minimum above maximum after a measure");

   a_start_from_ch: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == S_DIV))
      else $error("divider started without entering the divide state");
`endif

endmodule
